FILE: rtl/perturbed_probe_hash_table_top_defines.svh
// Assertion macros used by the checker file of the hash table.
`ifndef PERTURBED_PROBE_HASH_TABLE_TOP_DEFINES_SVH
`define PERTURBED_PROBE_HASH_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PPHT_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PPHT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: rtl/ppht_pkg.sv
`timescale 1ns / 1ps

package ppht_pkg;

  // Largest table: 2**MAX_TABLE_BITS slots in each store.
  localparam int MAX_TABLE_BITS = 10;
  localparam int MIN_TABLE_BITS = 3;
  localparam int STORE_DEPTH    = 1 << MAX_TABLE_BITS;
  // Counts and probe step counters must hold size + 8.
  localparam int CNT_W          = MAX_TABLE_BITS + 1;
  localparam int PERTURB_SHR_BITS = 5;

  // Request codes.
  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // Response status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_DUP    = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // Configuration register index (paddr bit 2 selects the word).
  localparam logic CFG_IDX_TABLE_BITS = 1'b0;
  localparam logic [3:0] TABLE_BITS_RESET = 4'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] key;
    logic [31:0] hash;
    logic [31:0] value;
  } ppht_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
    logic [9:0]  slot;
  } ppht_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic accept;
    logic probe;
    logic commit;
  } ppht_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic probe_done;
  } ppht_sts_t;

  // Load limit (size + 1) * 2 / 3 for each table size.
  function automatic logic [CNT_W-1:0] load_limit(input logic [3:0] bits);
    logic [CNT_W-1:0] lim;
    unique case (bits)
      4'd3:    lim = CNT_W'(6);
      4'd4:    lim = CNT_W'(11);
      4'd5:    lim = CNT_W'(22);
      4'd6:    lim = CNT_W'(43);
      4'd7:    lim = CNT_W'(86);
      4'd8:    lim = CNT_W'(171);
      4'd9:    lim = CNT_W'(342);
      4'd10:   lim = CNT_W'(683);
      default: lim = CNT_W'(6);
    endcase
    return lim;
  endfunction

endpackage

FILE: rtl/perturbed_probe_hash_table_top.sv
`timescale 1ns / 1ps
// Each accepted item probes P slots (1 to size + 8) and then its result is registered;
// the key and value stores give one slot a cycle.
// A new item is taken only once the last one has left its probe, but while its result waits.
// Reset: table_bits returns to 3 and a clearing pass zeroes all 1024 entries of both stores,
// during which req_ready stays low; configuration writes are taken throughout.
module perturbed_probe_hash_table_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  ppht_pkg::ppht_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output ppht_pkg::ppht_rsp_t rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int TB = ppht_pkg::MAX_TABLE_BITS;
  localparam int CW = ppht_pkg::CNT_W;

  logic [3:0]    table_bits;
  logic [3:0]    eff_bits;
  logic [TB-1:0] mask;
  logic [CW-1:0] last_n;
  logic [CW-1:0] load;

  ppht_pkg::ppht_cmd_t cmd;
  ppht_pkg::ppht_sts_t sts;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ppht_pkg::CFG_IDX_TABLE_BITS) ? {28'd0, table_bits} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_bits <= ppht_pkg::TABLE_BITS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == ppht_pkg::CFG_IDX_TABLE_BITS)) begin
      table_bits <= pwdata[3:0];
    end
  end

  // Table geometry from the clamped size.
  always_comb begin
    eff_bits = table_bits;
    if (table_bits < 4'(ppht_pkg::MIN_TABLE_BITS)) eff_bits = 4'(ppht_pkg::MIN_TABLE_BITS);
    if (table_bits > 4'(ppht_pkg::MAX_TABLE_BITS)) eff_bits = 4'(ppht_pkg::MAX_TABLE_BITS);
  end

  assign mask   = ~({TB{1'b1}} << eff_bits);
  assign last_n = (CW'(1) << eff_bits) + CW'(7);
  assign load   = ppht_pkg::load_limit(eff_bits);

  ppht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ppht_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .req    (req),
    .mask   (mask),
    .last_n (last_n),
    .load   (load),
    .rsp    (rsp)
  );

endmodule

FILE: rtl/ppht_ctrl.sv
`timescale 1ns / 1ps

module ppht_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  ppht_pkg::ppht_sts_t  sts,
  output ppht_pkg::ppht_cmd_t  cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       rsp_free;

  // The result register can take a new item when empty or being drained.
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  // Commands to the datapath.
  always_comb begin
    cmd.clear  = (state == S_CLEAR);
    cmd.accept = (state == S_IDLE) && req_valid;
    cmd.probe  = (state == S_PROBE);
    cmd.commit = (state == S_DONE) && rsp_free;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) state_next = S_PROBE;
      end
      S_PROBE: begin
        if (sts.probe_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (rsp_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // State and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/ppht_datapath.sv
`timescale 1ns / 1ps

module ppht_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ppht_pkg::ppht_cmd_t                  cmd,
  output ppht_pkg::ppht_sts_t                  sts,
  input  ppht_pkg::ppht_req_t                  req,
  input  logic [ppht_pkg::MAX_TABLE_BITS-1:0]  mask,
  input  logic [ppht_pkg::CNT_W-1:0]           last_n,
  input  logic [ppht_pkg::CNT_W-1:0]           load,
  output ppht_pkg::ppht_rsp_t                  rsp
);

  localparam int TB = ppht_pkg::MAX_TABLE_BITS;
  localparam int CW = ppht_pkg::CNT_W;

  // Key and value stores.
  logic [31:0] key_mem [ppht_pkg::STORE_DEPTH];
  logic [31:0] val_mem [ppht_pkg::STORE_DEPTH];
  logic [31:0] key_rd;
  logic [31:0] val_rd;
  logic [TB-1:0] rd_addr;
  logic [TB-1:0] clr_addr;

  // Probe state and the captured request.
  logic [TB-1:0] idx;
  logic [TB-1:0] idx_next;
  logic [31:0]   perturb;
  logic [CW-1:0] n;
  ppht_pkg::ppht_req_t cur;

  // Where the probe stopped.
  logic          hit;
  logic [TB-1:0] slot;
  logic [31:0]   st_key;
  logic [31:0]   st_val;

  logic [CW-1:0] used;

  logic          match;
  logic          last_step;

  // Outcome of the finished probe.
  logic [1:0]  o_status;
  logic [31:0] o_vout;
  logic        wr_key;
  logic        wr_val;
  logic [31:0] wr_val_data;
  logic        used_inc;

  // Next probe index: (5*i + perturb + 1) within the table mask.
  assign idx_next = ({idx[TB-3:0], 2'b00} + idx + perturb[TB-1:0] + TB'(1)) & mask;

  // A new item reads its home slot; afterwards the next slot is read every cycle.
  assign rd_addr = cmd.accept ? (req.hash[TB-1:0] & mask) : idx_next;

  assign match     = (key_rd == cur.key) || (key_rd == 32'd0);
  assign last_step = (n == last_n);

  assign sts.probe_done = match || last_step;
  assign sts.clear_done = (clr_addr == {TB{1'b1}});

  // Store reads and writes; the clearing pass zeroes one entry a cycle.
  always_ff @(posedge clk) begin
    key_rd <= key_mem[rd_addr];
    val_rd <= val_mem[rd_addr];
    if (cmd.clear) begin
      key_mem[clr_addr] <= 32'd0;
      val_mem[clr_addr] <= 32'd0;
    end else if (cmd.commit) begin
      if (wr_key) key_mem[slot] <= cur.key;
      if (wr_val) val_mem[slot] <= wr_val_data;
    end
  end

  // Clearing pass address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + TB'(1);
    end
  end

  // Probe walk: one slot checked per cycle.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur     <= req;
      idx     <= req.hash[TB-1:0] & mask;
      perturb <= req.hash;
      n       <= '0;
    end else if (cmd.probe) begin
      if (match) begin
        hit    <= 1'b1;
        slot   <= idx;
        st_key <= key_rd;
        st_val <= val_rd;
      end else if (last_step) begin
        hit    <= 1'b0;
        slot   <= idx_next;
        st_key <= key_rd;
        st_val <= 32'd0;
      end else begin
        idx     <= idx_next;
        perturb <= perturb >> ppht_pkg::PERTURB_SHR_BITS;
        n       <= n + CW'(1);
      end
    end
  end

  // Decide the result and the store updates.
  always_comb begin
    o_status    = ppht_pkg::ST_ABSENT;
    o_vout      = 32'd0;
    wr_key      = 1'b0;
    wr_val      = 1'b0;
    wr_val_data = cur.value;
    used_inc    = 1'b0;
    if (!hit) begin
      o_status = (cur.req_type == ppht_pkg::REQ_INSERT) ? ppht_pkg::ST_FULL
                                                        : ppht_pkg::ST_ABSENT;
    end else if (cur.key == 32'd0) begin
      o_status = ppht_pkg::ST_ABSENT;
    end else begin
      case (cur.req_type)
        ppht_pkg::REQ_INSERT: begin
          if (st_val != 32'd0) begin
            o_status = ppht_pkg::ST_DUP;
            o_vout   = st_val;
          end else if (cur.value == 32'd0) begin
            o_status = ppht_pkg::ST_ABSENT;
          end else if (used >= load) begin
            o_status = ppht_pkg::ST_FULL;
          end else begin
            o_status = ppht_pkg::ST_OK;
            wr_key   = 1'b1;
            wr_val   = 1'b1;
            used_inc = (st_key == 32'd0);
          end
        end
        ppht_pkg::REQ_REMOVE: begin
          // A remove leaves the key behind as a tombstone.
          o_vout = st_val;
          if (st_val != 32'd0) begin
            o_status    = ppht_pkg::ST_OK;
            wr_val      = 1'b1;
            wr_val_data = 32'd0;
          end
        end
        default: begin
          // Lookup; the unused request code is treated the same way.
          o_vout   = st_val;
          o_status = (st_val != 32'd0) ? ppht_pkg::ST_OK : ppht_pkg::ST_ABSENT;
        end
      endcase
    end
  end

  // Count of slots whose key has ever been written.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.commit && used_inc) begin
      used <= used + CW'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.status    <= o_status;
      rsp.value_out <= o_vout;
      rsp.slot      <= 10'(slot);
    end
  end

endmodule

FILE: rtl/ppht_checker.sv
`timescale 1ns / 1ps
`include "perturbed_probe_hash_table_top_defines.svh"

module ppht_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input ppht_pkg::ppht_rsp_t rsp
);

  logic [1:0] pend;
  logic       req_fire;
  logic       rsp_fire;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  // Items accepted whose result has not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 2'd0;
    end else begin
      pend <= pend + 2'(req_fire) - 2'(rsp_fire);
    end
  end

  // A result is only shown for an item that was accepted.
  `PPHT_ASSERT_NOW(a_no_orphan_rsp, rsp_valid, pend != 2'd0)
  // At most one result may wait while a further item is taken.
  `PPHT_ASSERT_NOW(a_depth, req_fire, pend != 2'd2 && pend != 2'd3)
  // An item is worked on alone: the input closes right after acceptance.
  `PPHT_ASSERT_NEXT(a_one_in_flight, req_fire, !req_ready)
  // A stalled result keeps its payload.
  `PPHT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind perturbed_probe_hash_table_top ppht_checker u_ppht_checker (.*);

FILE: tb/sv/hash_table_checker.sv
`timescale 1ns / 1ps

// Watches the request, response and register channels of the hash table.
// It keeps its own copy of both stores, predicts the response of every
// accepted request and compares each returned response with the oldest one.
module hash_table_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_ready,
  input  ppht_pkg::ppht_req_t req,
  input  logic                rsp_valid,
  input  logic                rsp_ready,
  input  ppht_pkg::ppht_rsp_t rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  input  logic                end_check,
  output int                  fail_count
);

  import ppht_pkg::*;

  // Shadow copy of the table and its register.
  logic [31:0]      key_mem [STORE_DEPTH];
  logic [31:0]      val_mem [STORE_DEPTH];
  logic [CNT_W-1:0] used_cnt;
  logic [CNT_W-1:0] live_cnt;
  logic [3:0]       tbits;

  // Responses predicted for requests that are still in flight.
  ppht_rsp_t pending_rsp_q [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got 0x%08h, expected 0x%08h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // Runs one request against the shadow table, updating it as the block would.
  function automatic ppht_rsp_t predict_table_access(input ppht_req_t r);
    logic [3:0]  eff;
    logic [31:0] size;
    logic [31:0] mask;
    logic [31:0] limit;
    logic [31:0] perturb;
    logic [31:0] pos;
    logic [31:0] k;
    logic [9:0]  idx;
    logic        hit;
    ppht_rsp_t   o;
    eff = tbits;
    if (eff < MIN_TABLE_BITS) eff = 4'(MIN_TABLE_BITS);
    if (eff > MAX_TABLE_BITS) eff = 4'(MAX_TABLE_BITS);
    size    = 32'd1 << eff;
    mask    = size - 32'd1;
    perturb = r.hash;
    pos     = r.hash & mask;
    hit     = 1'b0;

    // Walk the perturbed probe sequence until a matching or empty slot.
    for (int n = 0; n < size + 32'd8 && !hit; n++) begin
      k = key_mem[pos[9:0]];
      if (k == r.key || k == 32'd0) begin
        hit = 1'b1;
      end else begin
        pos     = (32'd5 * pos + perturb + 32'd1) & mask;
        perturb = perturb >> PERTURB_SHR_BITS;
      end
    end

    idx         = pos[9:0];
    o.slot      = idx;
    o.status    = ST_ABSENT;
    o.value_out = '0;
    if (!hit) begin
      o.status = (r.req_type == REQ_INSERT) ? ST_FULL : ST_ABSENT;
    end else if (r.key == 32'd0) begin
      o.status = ST_ABSENT;
    end else if (r.req_type == REQ_INSERT) begin
      limit = ((size + 32'd1) * 32'd2) / 32'd3;
      if (val_mem[idx] != 32'd0) begin
        o.status    = ST_DUP;
        o.value_out = val_mem[idx];
      end else if (r.value == 32'd0) begin
        o.status = ST_ABSENT;
      end else if (32'(used_cnt) >= limit) begin
        o.status = ST_FULL;
      end else begin
        if (key_mem[idx] == 32'd0) used_cnt++;
        key_mem[idx] = r.key;
        val_mem[idx] = r.value;
        live_cnt++;
        o.status = ST_OK;
      end
    end else if (r.req_type == REQ_REMOVE) begin
      // The key stays behind as a tombstone.
      o.value_out = val_mem[idx];
      if (val_mem[idx] != 32'd0) begin
        val_mem[idx] = '0;
        if (live_cnt != '0) live_cnt--;
        o.status = ST_OK;
      end
    end else begin
      o.value_out = val_mem[idx];
      o.status    = (val_mem[idx] != 32'd0) ? ST_OK : ST_ABSENT;
    end
    return o;
  endfunction

  always @(posedge clk) begin
    ppht_rsp_t want;
    if (rst) begin
      for (int j = 0; j < STORE_DEPTH; j++) begin
        key_mem[j] = '0;
        val_mem[j] = '0;
      end
      used_cnt = '0;
      live_cnt = '0;
      tbits    = TABLE_BITS_RESET;
      pending_rsp_q.delete();
    end else begin
      // Register write in the access phase.
      if (psel && penable && pwrite && pready && paddr[2] == CFG_IDX_TABLE_BITS) begin
        tbits = pwdata[3:0];
      end

      // Compare a returned response with the oldest prediction.
      if (rsp_valid && rsp_ready) begin
        if (pending_rsp_q.size() == 0) begin
          report_mismatch("response with no request outstanding", 32'(rsp.slot), 32'd0);
        end else begin
          want = pending_rsp_q.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", 32'(rsp.status), 32'(want.status));
          if (rsp.value_out !== want.value_out)
            report_mismatch("value_out", rsp.value_out, want.value_out);
          if (rsp.slot !== want.slot)
            report_mismatch("slot", 32'(rsp.slot), 32'(want.slot));
        end
      end

      if (req_valid && req_ready) begin
        pending_rsp_q.push_back(predict_table_access(req));
      end

      if (end_check && pending_rsp_q.size() != 0) begin
        report_mismatch("responses never returned", 32'(pending_rsp_q.size()), 32'd0);
      end
    end
  end

endmodule

FILE: tb/sv/perturbed_probe_hash_table_top_test.sv
`timescale 1ns / 1ps

module perturbed_probe_hash_table_top_test;

  import ppht_pkg::*;

  localparam int RESET_CYCLES    = 5;
  localparam int CYCLE_LIMIT     = 10_000_000;
  localparam int IDLE_PAD        = 4;
  localparam int TAIL_CYCLES     = STORE_DEPTH + 10;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS     = 150;
  localparam int NUM_PHASES      = 12;
  localparam int POOL_CAP        = 2000;
  localparam int MAX_GAP         = 13;

  localparam logic [1:0] REQ_UNKNOWN     = 2'd3;
  localparam logic [2:0] TABLE_BITS_ADDR = {CFG_IDX_TABLE_BITS, 2'b00};

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  ppht_req_t   req       = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  ppht_rsp_t   rsp;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        end_check = 1'b0;
  int          fail_count;

  // Handshake bookkeeping shared by the sender and the receiver.
  int   req_sent     = 0;
  int   rsp_got      = 0;
  int   cycle_cnt    = 0;
  bit   no_idle      = 1'b0;
  bit   hold_off_req = 1'b0;

  // Keys handed out so far, each with the hash it always travels with.
  logic [31:0] key_pool  [$];
  logic [31:0] hash_pool [$];

  // Table bits for each random phase; out-of-range values clamp in the block.
  logic [3:0] phase_bits [NUM_PHASES] = '{4'd10, 4'd4, 4'd15, 4'd3, 4'd7, 4'd0,
                                          4'd9, 4'd10, 4'd6, 4'd8, 4'd12, 4'd5};

  perturbed_probe_hash_table_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  hash_table_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .end_check  (end_check),
    .fail_count (fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Response side: random back-pressure, with one long hold-off on request.
  initial begin
    int gap;
    wait (rst === 1'b0);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = HOLD_OFF_CYCLES;
      end else if (no_idle) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (rsp_valid !== 1'b1);
      rsp_got++;
    end
  end

  function automatic ppht_req_t req_item(input logic [1:0] kind, input logic [31:0] key,
                                         input logic [31:0] hash, input logic [31:0] value);
    ppht_req_t item;
    item.req_type = kind;
    item.key      = key;
    item.hash     = hash;
    item.value    = value;
    return item;
  endfunction

  function automatic logic [31:0] fresh_value();
    logic [31:0] v;
    v = $urandom();
    if ($urandom_range(0, 15) == 0) v = '1;
    if (v == 32'd0) v = 32'd1;
    return v;
  endfunction

  // Mostly well-formed traffic on known keys, with some malformed requests mixed in.
  function automatic ppht_req_t random_table_req();
    ppht_req_t item;
    int        pick;
    int        sel;
    item = req_item(REQ_LOOKUP, 32'd1, $urandom(), $urandom());
    pick = $urandom_range(0, 99);
    sel  = (key_pool.size() == 0) ? 0 : $urandom_range(0, key_pool.size() - 1);
    if (key_pool.size() == 0 || pick < 35) begin
      item.req_type = REQ_INSERT;
      item.key      = $urandom();
      if (item.key == 32'd0) item.key = 32'd1;
      // Now and then reuse a hash so that two keys share a whole probe path.
      if (key_pool.size() != 0 && $urandom_range(0, 3) == 0) item.hash = hash_pool[sel];
      item.value = fresh_value();
      key_pool.push_back(item.key);
      hash_pool.push_back(item.hash);
      if (key_pool.size() > POOL_CAP) begin
        void'(key_pool.pop_front());
        void'(hash_pool.pop_front());
      end
    end else begin
      item.key  = key_pool[sel];
      item.hash = hash_pool[sel];
      if (pick < 55) begin
        item.req_type = REQ_INSERT;
        item.value    = fresh_value();
      end else if (pick < 75) begin
        item.req_type = REQ_LOOKUP;
      end else if (pick < 88) begin
        item.req_type = REQ_REMOVE;
      end else begin
        case ($urandom_range(0, 4))
          0: begin
            item.req_type = 2'($urandom_range(0, 3));
            item.key      = $urandom();
            item.hash     = $urandom();
          end
          1: begin
            item.req_type = 2'($urandom_range(0, 3));
            item.key      = '0;
          end
          2: begin
            item.req_type = REQ_INSERT;
            item.value    = '0;
          end
          3: item.req_type = REQ_UNKNOWN;
          default: item.hash = $urandom();
        endcase
      end
    end
    return item;
  endfunction

  // Offers one item after a random gap and waits until it is accepted.
  task automatic send_req(input ppht_req_t item);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_ready !== 1'b1);
    req_sent++;
  endtask

  // Stops offering and waits until every response is back.
  task automatic wait_drain(input int pad);
    req_valid <= 1'b0;
    while (rsp_got != req_sent) @(posedge clk);
    repeat (pad) @(posedge clk);
  endtask

  task automatic write_table_bits(input logic [3:0] bits);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TABLE_BITS_ADDR;
    pwdata  <= {28'($urandom()), bits};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Below the legal range; the block clamps it to the smallest table.
    write_table_bits(4'd0);

    // Eight-slot table: collisions, duplicates and the zero key and value.
    send_req(req_item(REQ_INSERT, 32'h1, 32'h0, 32'hFFFF_FFFF));
    send_req(req_item(REQ_INSERT, 32'h2, 32'h0, 32'h1));
    send_req(req_item(REQ_INSERT, 32'h1, 32'h0, 32'h5));
    send_req(req_item(REQ_INSERT, 32'h1, 32'h0, 32'h0));
    send_req(req_item(REQ_INSERT, 32'h3, 32'h2, 32'h0));
    send_req(req_item(REQ_INSERT, 32'h0, 32'hFFFF_FFFF, 32'h3));
    send_req(req_item(REQ_UNKNOWN, 32'h2, 32'h0, 32'h0));

    // Tombstones: removal, second removal, lookup, removal from an empty slot, reuse.
    send_req(req_item(REQ_REMOVE, 32'h1, 32'h0, 32'h0));
    send_req(req_item(REQ_REMOVE, 32'h1, 32'h0, 32'h0));
    send_req(req_item(REQ_LOOKUP, 32'h1, 32'h0, 32'h0));
    send_req(req_item(REQ_REMOVE, 32'h9, 32'h5, 32'h0));
    send_req(req_item(REQ_INSERT, 32'h1, 32'h0, 32'h7));
    send_req(req_item(REQ_LOOKUP, 32'h1, 32'h0, 32'h0));

    // Fill to the load limit, then a new key and a tombstone of the same key are refused.
    send_req(req_item(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_5555));
    send_req(req_item(REQ_INSERT, 32'h4, 32'h3, 32'h1234_5678));
    send_req(req_item(REQ_INSERT, 32'h5, 32'h4, 32'h8000_0000));
    send_req(req_item(REQ_INSERT, 32'h6, 32'h5, 32'h0000_0001));
    send_req(req_item(REQ_INSERT, 32'h7, 32'h6, 32'h9));
    send_req(req_item(REQ_REMOVE, 32'h2, 32'h0, 32'h0));
    send_req(req_item(REQ_INSERT, 32'h2, 32'h0, 32'h2));

    // Grow the table and take the two slots still free among the first eight.
    wait_drain(IDLE_PAD);
    write_table_bits(4'd15);
    send_req(req_item(REQ_INSERT, 32'h8, 32'h2, 32'h55AA_55AA));
    send_req(req_item(REQ_INSERT, 32'hA, 32'h6, 32'h0F0F_0F0F));

    // Shrink again: every slot holds a key, so the probe runs out.
    wait_drain(IDLE_PAD);
    write_table_bits(4'd3);
    send_req(req_item(REQ_LOOKUP, 32'hB, 32'h1234, 32'h0));
    send_req(req_item(REQ_INSERT, 32'hB, 32'h1234, 32'h77));

    // Random phases, each at its own table size.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drain(IDLE_PAD);
      write_table_bits(phase_bits[ph]);
      no_idle = (ph % 4 == 1);
      if (ph == 2 || ph == 7) hold_off_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_req(random_table_req());
      end
    end
    no_idle = 1'b0;

    wait_drain(TAIL_CYCLES);
    end_check <= 1'b1;
    @(posedge clk);
    end_check <= 1'b0;
    @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
